// ===== rtl/sws_pkg.sv =====
package sws_pkg;

    typedef enum logic [1:0] {
        OUT_NONE    = 2'd0,
        OUT_OVERLAP = 2'd1,
        OUT_HIT     = 2'd2
    } t_outcome;

    // Item as it enters the block, plus the gap between the surfaces.
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][31:0] m;
        logic [30:0]      cdist;
        logic [30:0]      rss;
        logic [32:0]      gap;
    } t_front;

    // After the move length is known.
    typedef struct packed {
        t_front      f;
        logic [31:0] len;
        logic        ovl;
        logic        shrt;
    } t_mid;

    // Everything the back half of the pipe needs.
    typedef struct packed {
        logic [2:0][31:0] m;
        logic [2:0][31:0] n;
        logic [31:0]      len;
        logic [31:0]      dsat;
        logic [30:0]      cdist;
        logic [30:0]      rss;
        logic             ovl;
        logic             shrt;
        logic             away;
        logic             far;
        logic             miss;
    } t_back;

    typedef struct packed {
        t_outcome         outcome;
        logic [2:0][31:0] mv;
    } t_result;

endpackage

// ===== rtl/sws_isqrt.sv =====
module sws_isqrt #(
    parameter int IN_W = 64,
    parameter int SB_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [SB_W-1:0]     o_sb
);
    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic              r_v    [OUT_W];
    logic [REM_W-1:0]  r_rem  [OUT_W];
    logic [OUT_W-1:0]  r_root [OUT_W];
    logic [IN_W-1:0]   r_rad  [OUT_W];
    logic [SB_W-1:0]   r_sb   [OUT_W];

    // One result bit per stage, most significant first (restoring square root).
    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int J = OUT_W - 1 - k;
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [IN_W-1:0]   rad_in;
        logic [SB_W-1:0]   sb_in;
        logic [REM_W+1:0]  cat;
        logic [REM_W+1:0]  trial;
        logic              fits;
        logic [REM_W-1:0]  n_rem;
        logic [OUT_W-1:0]  n_root;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign sb_in   = i_sb;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign sb_in   = r_sb[k-1];
        end

        assign cat    = {rem_in, rad_in[2*J+1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign fits   = (cat >= trial);
        assign n_rem  = fits ? REM_W'(cat - trial) : REM_W'(cat);
        assign n_root = {root_in[OUT_W-2:0], fits};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= rad_in;
                r_sb[k]   <= sb_in;
            end
        end
    end

    assign o_valid = r_v[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];
    assign o_sb    = r_sb[OUT_W-1];

endmodule

// ===== rtl/sws_div.sv =====
module sws_div #(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [2:0][31:0]           i_num,
    input  logic [31:0]                i_den,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_valid,
    output logic [2:0][FRAC_BITS:0]    o_quot,
    output logic [SB_W-1:0]            o_sb
);
    localparam int Q_W = FRAC_BITS + 1;

    logic                   r_v   [Q_W];
    logic [2:0][31:0]       r_rem [Q_W];
    logic [2:0][Q_W-1:0]    r_q   [Q_W];
    logic [31:0]            r_den [Q_W];
    logic [SB_W-1:0]        r_sb  [Q_W];

    // Each numerator is a magnitude that never exceeds the divisor and is in
    // effect shifted up by FRAC_BITS, so the quotient fits in FRAC_BITS+1 bits
    // and the partial remainder always stays below the divisor.
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic                v_in;
        logic [2:0][31:0]    rem_in;
        logic [2:0][Q_W-1:0] q_in;
        logic [31:0]         den_in;
        logic [SB_W-1:0]     sb_in;
        logic [2:0]          sh;
        logic [2:0][31:0]    n_rem;
        logic [2:0][Q_W-1:0] n_q;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign den_in = i_den;
            assign sb_in  = i_sb;
            assign q_in   = '0;
            for (genvar l = 0; l < 3; l++) begin : g_init
                assign rem_in[l] = {1'b0, i_num[l][31:1]};
                assign sh[l]     = i_num[l][0];
            end
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign den_in = r_den[k-1];
            assign sb_in  = r_sb[k-1];
            assign sh     = '0;
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [32:0] cat;
            logic        fits;
            assign cat      = {rem_in[l], sh[l]};
            assign fits     = (cat >= {1'b0, den_in});
            assign n_rem[l] = fits ? 32'(cat - {1'b0, den_in}) : cat[31:0];
            assign n_q[l]   = {q_in[l][Q_W-2:0], fits};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_den[k] <= den_in;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_q[Q_W-1];
    assign o_sb    = r_sb[Q_W-1];

endmodule

// ===== rtl/swept_sphere_collision_test.sv =====
// Swept sphere test: one sphere moves by a vector towards another sphere.
// Input channel: i_valid / o_stall with the centre offset, centre distance,
// radius sum, its square and the move vector (all fixed point, FRAC_BITS
// fraction bits). An item is taken on a rising edge with i_valid high and
// o_stall low.
// Output channel: o_valid / i_stall with the outcome code (none, already
// overlapping, hit) and the returned move vector: unchanged, normalised, or
// cut to the contact distance on a hit.
// Throughput is one item per cycle while o_stall is low. The pipe is built
// from two 32-stage square root pipes, a FRAC_BITS+1 stage divider that
// normalises the move, and thirteen input, arithmetic and output stages.
// The whole pipe advances together; a one-item skid buffer behind the output
// register lets one more item drain when the receiver stalls, after which
// o_stall rises and nothing moves until the skid buffer empties. Stalling
// loses and repeats nothing. Synchronous reset clears every valid bit and
// the skid buffer; items in flight are dropped.
module swept_sphere_collision_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_offset_x,
    input  logic signed [31:0]   i_offset_y,
    input  logic signed [31:0]   i_offset_z,
    input  logic [30:0]          i_center_distance,
    input  logic [30:0]          i_radius_sum,
    input  logic [30:0]          i_radius_sum_squared,
    input  logic signed [31:0]   i_move_x,
    input  logic signed [31:0]   i_move_y,
    input  logic signed [31:0]   i_move_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_outcome,
    output logic signed [31:0]   o_new_move_x,
    output logic signed [31:0]   o_new_move_y,
    output logic signed [31:0]   o_new_move_z
);
    import sws_pkg::*;

    localparam int NW  = FRAC_BITS + 2;     // normalised component, signed
    localparam int PW  = NW + 32;           // n * offset
    localparam int DW  = PW + 2;            // dot product
    localparam int CW  = 34;                // contact distance, signed
    localparam int P2W = NW + CW;           // n * contact

    logic en;

    // Stage 0: input register.
    logic             r0_v;
    t_front           r0_f;
    logic [30:0]      r0_rsum;

    // Stage 1: squares of the move components.
    logic             r1_v;
    t_front           r1_f;
    logic [2:0][63:0] r1_sq;

    // Stage 2: squared length.
    logic             r2_v;
    t_front           r2_f;
    logic [63:0]      r2_sum;

    logic             w_q1_v;
    logic [31:0]      w_len;
    logic [$bits(t_front)-1:0] w_q1_sb;
    t_front           w_q1_f;

    // Stage 3: early checks, magnitudes for the divider.
    logic             r3_v;
    t_mid             r3_mid;
    logic [2:0][31:0] r3_mag;

    logic                     w_dv_v;
    logic [2:0][FRAC_BITS:0]  w_quot;
    logic [$bits(t_mid)-1:0]  w_dv_sb;
    t_mid                     w_mid;

    // Stages 4 to 9.
    logic                 r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    t_back                r4_b, r5_b, r6_b, r7_b, r8_b, r9_b;
    logic [2:0][31:0]     r4_c;
    logic [2:0][PW-1:0]   r5_prod;
    logic [DW-1:0]        r6_dot;
    logic [63:0]          r8_d2, r8_dist2, r8_rss2;
    logic [63:0]          r9_t;

    logic             w_q2_v;
    logic [31:0]      w_root;
    logic [$bits(t_back)-1:0] w_q2_sb;
    t_back            w_back;

    // Stages 10 and 11.
    logic                 r10_v, r11_v;
    t_back                r10_b, r11_b;
    logic [CW-1:0]        r10_contact;
    logic [2:0][P2W-1:0]  r11_prod;

    // Output register and skid buffer.
    logic    r_out_v, r_skid_v;
    t_result r_out_d, r_skid_d;
    t_result w_res;

    assign en = !r_skid_v;

    // ---------------------------------------------------------------- front
    logic [32:0]      w0_gap;
    logic [2:0][31:0] w1_mag;
    t_front           n1_f;

    assign w0_gap = {2'b00, r0_f.cdist} - {2'b00, r0_rsum};

    always_comb begin
        n1_f     = r0_f;
        n1_f.gap = w0_gap;
    end

    for (genvar l = 0; l < 3; l++) begin : g_mag1
        assign w1_mag[l] = r0_f.m[l][31] ? (32'd0 - r0_f.m[l]) : r0_f.m[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= w_q1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_f.c     <= {i_offset_z, i_offset_y, i_offset_x};
            r0_f.m     <= {i_move_z, i_move_y, i_move_x};
            r0_f.cdist <= i_center_distance;
            r0_f.rss   <= i_radius_sum_squared;
            r0_f.gap   <= '0;
            r0_rsum    <= i_radius_sum;

            r1_f <= n1_f;
            for (int l = 0; l < 3; l++) begin
                r1_sq[l] <= w1_mag[l] * w1_mag[l];
            end

            r2_f   <= r1_f;
            r2_sum <= r1_sq[0] + r1_sq[1] + r1_sq[2];
        end
    end

    sws_isqrt #(
        .IN_W (64),
        .SB_W ($bits(t_front))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_rad   (r2_sum),
        .i_sb    (r2_f),
        .o_valid (w_q1_v),
        .o_root  (w_len),
        .o_sb    (w_q1_sb)
    );

    assign w_q1_f = w_q1_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mid.f    <= w_q1_f;
            r3_mid.len  <= w_len;
            r3_mid.ovl  <= w_q1_f.gap[32];
            r3_mid.shrt <= !w_q1_f.gap[32] && ({1'b0, w_len} < w_q1_f.gap);
            for (int l = 0; l < 3; l++) begin
                r3_mag[l] <= w_q1_f.m[l][31] ? (32'd0 - w_q1_f.m[l]) : w_q1_f.m[l];
            end
        end
    end

    sws_div #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      ($bits(t_mid))
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_num   (r3_mag),
        .i_den   (r3_mid.len),
        .i_sb    (r3_mid),
        .o_valid (w_dv_v),
        .o_quot  (w_quot),
        .o_sb    (w_dv_sb)
    );

    assign w_mid = w_dv_sb;

    // ---------------------------------------------------------------- middle
    logic [2:0][31:0] w4_n;
    logic [DW-1:0]    w7_mag_full;
    logic [DW-1:0]    w7_mag;
    logic             w7_away;
    logic [31:0]      w7_dsat;
    logic             w9_far;
    logic [64:0]      w9_sum;
    logic [63:0]      w9_t;
    t_back            n7_b;
    t_back            n9_b;

    // A zero-length move normalises to the zero vector.
    for (genvar l = 0; l < 3; l++) begin : g_norm
        logic [31:0] q;
        assign q       = (w_mid.len == 32'd0) ? 32'd0 : 32'(w_quot[l]);
        assign w4_n[l] = w_mid.f.m[l][31] ? (32'd0 - q) : q;
    end

    assign w7_mag_full = r6_dot[DW-1] ? (DW'(0) - r6_dot) : r6_dot;
    assign w7_mag      = w7_mag_full >> FRAC_BITS;
    assign w7_away     = r6_dot[DW-1] || (w7_mag == DW'(0));
    assign w7_dsat     = (w7_mag > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w7_mag[31:0];

    assign w9_far = (r8_dist2 >= r8_d2) && ((r8_dist2 - r8_d2) >= r8_rss2);
    assign w9_sum = {1'b0, r8_rss2} + {1'b0, r8_d2 - r8_dist2};
    assign w9_t   = (r8_d2 >= r8_dist2) ? (w9_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w9_sum[63:0])
                                        : (r8_rss2 - (r8_dist2 - r8_d2));

    always_comb begin
        n7_b      = r6_b;
        n7_b.away = w7_away;
        n7_b.dsat = w7_dsat;
    end

    always_comb begin
        n9_b     = r8_b;
        n9_b.far = w9_far;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (en) begin
            r4_v <= w_dv_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_b.m     <= w_mid.f.m;
            r4_b.n     <= w4_n;
            r4_b.len   <= w_mid.len;
            r4_b.dsat  <= '0;
            r4_b.cdist <= w_mid.f.cdist;
            r4_b.rss   <= w_mid.f.rss;
            r4_b.ovl   <= w_mid.ovl;
            r4_b.shrt  <= w_mid.shrt;
            r4_b.away  <= 1'b0;
            r4_b.far   <= 1'b0;
            r4_b.miss  <= 1'b0;
            r4_c       <= w_mid.f.c;

            r5_b <= r4_b;
            for (int l = 0; l < 3; l++) begin
                r5_prod[l] <= PW'($signed(r4_b.n[l][NW-1:0]) * $signed(r4_c[l]));
            end

            r6_b   <= r5_b;
            r6_dot <= DW'($signed(r5_prod[0])) + DW'($signed(r5_prod[1]))
                    + DW'($signed(r5_prod[2]));

            r7_b <= n7_b;

            r8_b     <= r7_b;
            r8_d2    <= r7_b.dsat * r7_b.dsat;
            r8_dist2 <= 64'(r7_b.cdist) * 64'(r7_b.cdist);
            r8_rss2  <= 64'(r7_b.rss) << FRAC_BITS;

            r9_b <= n9_b;
            r9_t <= w9_t;
        end
    end

    sws_isqrt #(
        .IN_W (64),
        .SB_W ($bits(t_back))
    ) u_contact_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_rad   (r9_t),
        .i_sb    (r9_b),
        .o_valid (w_q2_v),
        .o_root  (w_root),
        .o_sb    (w_q2_sb)
    );

    assign w_back = w_q2_sb;

    // ---------------------------------------------------------------- back
    logic [CW-1:0] w10_contact;
    t_back         n10_b;

    assign w10_contact = {2'b00, w_back.dsat} - {2'b00, w_root};

    always_comb begin
        n10_b      = w_back;
        n10_b.miss = $signed({2'b00, w_back.len}) < $signed(w10_contact);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
            r11_v <= 1'b0;
        end else if (en) begin
            r10_v <= w_q2_v;
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_b       <= n10_b;
            r10_contact <= w10_contact;

            r11_b <= r10_b;
            for (int l = 0; l < 3; l++) begin
                r11_prod[l] <= P2W'($signed(r10_b.n[l][NW-1:0]) * $signed(r10_contact));
            end
        end
    end

    // Scale back to FRAC_BITS toward zero, then clamp to the signed 32-bit range.
    logic [2:0][31:0] w_hit;

    for (genvar l = 0; l < 3; l++) begin : g_scale
        logic           neg;
        logic [P2W-1:0] mag;
        assign neg = r11_prod[l][P2W-1];
        assign mag = (neg ? (P2W'(0) - r11_prod[l]) : r11_prod[l]) >> FRAC_BITS;
        always_comb begin
            if (mag >= P2W'(33'h0_8000_0000)) begin
                w_hit[l] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                w_hit[l] = neg ? (32'd0 - mag[31:0]) : mag[31:0];
            end
        end
    end

    always_comb begin
        if (r11_b.ovl) begin
            w_res.outcome = OUT_OVERLAP;
            w_res.mv      = r11_b.m;
        end else if (r11_b.shrt) begin
            w_res.outcome = OUT_NONE;
            w_res.mv      = r11_b.m;
        end else if (r11_b.away || r11_b.far || r11_b.miss) begin
            w_res.outcome = OUT_NONE;
            w_res.mv      = r11_b.n;
        end else begin
            w_res.outcome = OUT_HIT;
            w_res.mv      = w_hit;
        end
    end

    // Output register with a one-item skid buffer behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (r_out_v && i_stall) begin
            r_skid_v <= r11_v;
        end else begin
            r_out_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_stall) begin
                r_out_d <= r_skid_d;
            end
        end else if (r_out_v && i_stall) begin
            r_skid_d <= w_res;
        end else begin
            r_out_d <= w_res;
        end
    end

    assign o_stall      = r_skid_v;
    assign o_valid      = r_out_v;
    assign o_outcome    = r_out_d.outcome;
    assign o_new_move_x = r_out_d.mv[0];
    assign o_new_move_y = r_out_d.mv[1];
    assign o_new_move_z = r_out_d.mv[2];

endmodule

// ===== verif/swept_sphere_collision_test_tb.sv =====
module swept_sphere_collision_test_tb;
    import sws_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 78 + FRAC;
    localparam int N_RANDOM = 1200;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        cdist, rsum, rss;
        logic signed [31:0] mx, my, mz;
    } t_pair;

    typedef struct {
        t_outcome           code;
        logic signed [31:0] vx, vy, vz;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_offset_x = '0, i_offset_y = '0, i_offset_z = '0;
    logic [30:0] i_center_distance = '0, i_radius_sum = '0, i_radius_sum_squared = '0;
    logic signed [31:0] i_move_x = '0, i_move_y = '0, i_move_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_outcome;
    logic signed [31:0] o_new_move_x, o_new_move_y, o_new_move_z;

    swept_sphere_collision_test #(.FRAC_BITS(FRAC)) dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_pair   pending_pairs[$];
    t_answer expected_answers[$];
    int      n_errors = 0;
    int      idle_cycles = 0;
    bit      quiet_phase = 0;
    bit      long_hold_req = 0;
    bit      long_hold_done = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    int      long_hold = 0;

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // Shift of the magnitude by the fraction width, so the result rounds towards zero.
    function automatic longint trunc_frac(longint x);
        longint q;
        q = longint'(mag(x) >> FRAC);
        return x < 0 ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic t_answer sweep_test(t_pair p);
        t_answer a;
        longint c[3], m[3], n[3];
        logic [63:0] sumsq, len, d2, dist2, rss2, t, extra, q;
        longint gap, dot, d, contact;
        c[0] = p.cx; c[1] = p.cy; c[2] = p.cz;
        m[0] = p.mx; m[1] = p.my; m[2] = p.mz;
        sumsq = 0;
        dot = 0;
        for (int i = 0; i < 3; i++) sumsq += mag(m[i]) * mag(m[i]);
        len = root_floor(sumsq);
        gap = longint'(p.cdist) - longint'(p.rsum);
        a.code = OUT_NONE;
        a.vx = p.mx; a.vy = p.my; a.vz = p.mz;
        if (gap < 0) begin
            a.code = OUT_OVERLAP;
            return a;
        end
        if (longint'(len) < gap) return a;
        for (int i = 0; i < 3; i++) begin
            q = (len != 0) ? (mag(m[i]) << FRAC) / len : 64'd0;
            n[i] = m[i] < 0 ? -longint'(q) : longint'(q);
            dot += n[i] * c[i];
        end
        a.vx = 32'(n[0]); a.vy = 32'(n[1]); a.vz = 32'(n[2]);
        d = trunc_frac(dot);
        if (d <= 0) return a;
        if (d > 64'sh0ffffffff) d = 64'sh0ffffffff;
        d2 = 64'(d) * 64'(d);
        dist2 = 64'(p.cdist) * 64'(p.cdist);
        rss2 = 64'(p.rss) << FRAC;
        if (dist2 >= d2 && dist2 - d2 >= rss2) return a;
        if (d2 >= dist2) begin
            extra = d2 - dist2;
            t = (extra > ~64'd0 - rss2) ? ~64'd0 : rss2 + extra;
        end else begin
            t = rss2 - (dist2 - d2);
        end
        contact = d - longint'(root_floor(t));
        if (longint'(len) < contact) return a;
        a.code = OUT_HIT;
        a.vx = clamp32(trunc_frac(n[0] * contact));
        a.vy = clamp32(trunc_frac(n[1] * contact));
        a.vz = clamp32(trunc_frac(n[2] * contact));
        return a;
    endfunction

    function automatic logic signed [31:0] any32();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 3) - 1;
            default: return $urandom();
        endcase
    endfunction

    // Geometric pair: spheres a few units apart, moving roughly towards each other.
    function automatic t_pair near_pair();
        t_pair p;
        int unsigned sc;
        sc = 1 << $urandom_range(10, 20);
        p.cx = $signed($urandom_range(0, 8 * sc)) - 4 * sc;
        p.cy = $signed($urandom_range(0, 8 * sc)) - 4 * sc;
        p.cz = $signed($urandom_range(0, 8 * sc)) - 4 * sc;
        p.cdist = 31'(root_floor(64'(longint'(p.cx) * p.cx + longint'(p.cy) * p.cy
                                     + longint'(p.cz) * p.cz)));
        p.rsum = $urandom_range(0, 2 * sc);
        p.rss = 31'((64'(p.rsum) * 64'(p.rsum)) >> FRAC);
        p.mx = p.cx / 2 + $signed($urandom_range(0, sc)) - sc / 2;
        p.my = p.cy / 2 + $signed($urandom_range(0, sc)) - sc / 2;
        p.mz = p.cz / 2 + $signed($urandom_range(0, sc)) - sc / 2;
        if ($urandom_range(0, 3) == 0) begin
            p.mx = p.mx * 2; p.my = p.my * 2; p.mz = p.mz * 2;
        end
        return p;
    endfunction

    function automatic t_pair noise_pair();
        t_pair p;
        p.cx = any32(); p.cy = any32(); p.cz = any32();
        p.cdist = 31'(any32()); p.rsum = 31'(any32()); p.rss = 31'(any32());
        p.mx = any32(); p.my = any32(); p.mz = any32();
        return p;
    endfunction

    function automatic t_pair make_pair(logic signed [31:0] cx, logic signed [31:0] cdist,
                                        logic signed [31:0] rsum, logic signed [31:0] rss,
                                        logic signed [31:0] mx, logic signed [31:0] my);
        t_pair p;
        p.cx = cx; p.cy = 0; p.cz = 0;
        p.cdist = 31'(cdist); p.rsum = 31'(rsum); p.rss = 31'(rss);
        p.mx = mx; p.my = my; p.mz = 0;
        return p;
    endfunction

    task automatic add_pair(t_pair p);
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    task automatic queue_directed();
        localparam logic signed [31:0] ONE = 32'sh00010000;
        // Overlapping, move far too short, zero move, moving away.
        add_pair(make_pair(ONE, 32'sh8000, ONE, ONE, ONE, 0));
        add_pair(make_pair(10 * ONE, 10 * ONE, ONE, ONE, ONE, 0));
        add_pair(make_pair(ONE, ONE, ONE, ONE, 0, 0));
        add_pair(make_pair(4 * ONE, 4 * ONE, ONE, ONE, -8 * ONE, 0));
        // Passing by, and two clean head-on hits.
        add_pair(make_pair(4 * ONE, 4 * ONE, ONE, ONE, 8 * ONE, 8 * ONE));
        add_pair(make_pair(4 * ONE, 4 * ONE, ONE, ONE, 8 * ONE, 0));
        add_pair(make_pair(4 * ONE, 4 * ONE, 2 * ONE, 4 * ONE, 3 * ONE, 0));
        // Huge offsets; contact distance negative counts as a hit.
        add_pair(make_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                           32'sh7fffffff, 32'sh7fffffff, 0));
        add_pair(make_pair(32'sh7fffffff, 0, 0, 32'sh7fffffff,
                           32'sh7fffffff, 0));
        add_pair(make_pair(4 * ONE, 4 * ONE, 4 * ONE, 16 * ONE, ONE, 0));
        add_pair(make_pair(32'sh80000000, 32'sh7fffffff, 0, 0,
                           32'sh80000000, 32'sh80000000));
        add_pair(make_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7ffffff0,
                           32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        add_pair(make_pair(-1, 0, 0, 0, -1, 1));
        for (int i = 0; i < 8; i++) add_pair(noise_pair());
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_answers.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        queue_directed();
        wait_drained();
        // Receiver holds off while the sender keeps offering: the pipe must back up.
        long_hold_req = 1;
        for (int i = 0; i < 200; i++) add_pair(near_pair());
        wait (long_hold_done);
        for (int i = 0; i < N_RANDOM; i++) begin
            // Halfway through, the sender pauses until every result is back.
            if (i == N_RANDOM / 2) wait_drained();
            add_pair($urandom_range(0, 3) == 0 ? noise_pair() : near_pair());
        end
        while (pending_pairs.size() > 150) @(posedge i_clk);
        quiet_phase = 1;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (!quiet_phase && !long_hold_req && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 6);
                i_valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                t_pair p;
                p = pending_pairs.pop_front();
                expected_answers.insert(expected_answers.size(), sweep_test(p));
                i_offset_x <= p.cx; i_offset_y <= p.cy; i_offset_z <= p.cz;
                i_center_distance <= p.cdist;
                i_radius_sum <= p.rsum;
                i_radius_sum_squared <= p.rss;
                i_move_x <= p.mx; i_move_y <= p.my; i_move_z <= p.mz;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, including the one long hold-off.
    always @(posedge i_clk) begin
        if (long_hold_req && !long_hold_done) begin
            if (long_hold < 300) begin
                long_hold <= long_hold + 1;
                i_stall <= 1'b1;
            end else begin
                long_hold_done <= 1;
                long_hold_req <= 0;
                i_stall <= 1'b0;
            end
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 6);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || long_hold_req)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result with nothing expected: outcome %0d", $time, o_outcome);
                n_errors++;
            end else begin
                t_answer a;
                a = expected_answers.pop_front();
                if (o_outcome !== a.code) begin
                    $display("%0t: outcome expected %0d actual %0d", $time, a.code, o_outcome);
                    n_errors++;
                end
                if (o_new_move_x !== a.vx) begin
                    $display("%0t: new_move_x expected %0d actual %0d", $time, a.vx,
                             o_new_move_x);
                    n_errors++;
                end
                if (o_new_move_y !== a.vy) begin
                    $display("%0t: new_move_y expected %0d actual %0d", $time, a.vy,
                             o_new_move_y);
                    n_errors++;
                end
                if (o_new_move_z !== a.vz) begin
                    $display("%0t: new_move_z expected %0d actual %0d", $time, a.vz,
                             o_new_move_z);
                    n_errors++;
                end
            end
        end
    end

endmodule
